### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect signals named clk and rst_n in the including module.

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// An implication checked in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/cfmd_pkg.sv
`timescale 1ns / 1ps

package cfmd_pkg;

    // Largest payload of a frame; the length byte may reach this plus five.
    localparam int MAX_PAYLOAD = 10;

    // Byte counter within a message, saturating so long messages stay countable.
    localparam int POS_W = 9;
    localparam logic [POS_W-1:0] POS_LIMIT = 9'd511;

    localparam logic [7:0] SYNC0     = 8'h55;
    localparam logic [7:0] SYNC1     = 8'hAA;
    localparam logic [7:0] TAIL_CR   = 8'h0D;
    localparam logic [7:0] TAIL_LF   = 8'h0A;
    localparam logic [7:0] REPLY_LEN = 8'h06;
    localparam logic [7:0] REPLY_CTR = 8'h00;
    localparam logic [7:0] LEN_MIN   = 8'd6;
    localparam logic [7:0] LEN_MAX   = 8'(MAX_PAYLOAD + 5);

    // Positions of the fields inside a frame.
    localparam logic [POS_W-1:0] POS_SYNC0 = 9'd0;
    localparam logic [POS_W-1:0] POS_SYNC1 = 9'd1;
    localparam logic [POS_W-1:0] POS_LEN   = 9'd2;
    localparam logic [POS_W-1:0] POS_CS    = 9'd3;
    localparam logic [POS_W-1:0] POS_CMD   = 9'd5;
    localparam logic [POS_W-1:0] POS_PAY0  = 9'd6;
    localparam logic [POS_W-1:0] POS_PAY1  = 9'd7;

    // Command codes.
    localparam logic [7:0] CMD_BOARD_MODE   = 8'd0;
    localparam logic [7:0] CMD_DRIVE_MODE   = 8'd1;
    localparam logic [7:0] CMD_MOTOR        = 8'd2;
    localparam logic [7:0] CMD_STATUS       = 8'd3;

    // Item and result kinds.
    localparam logic OP_BYTE     = 1'b0;
    localparam logic OP_TICK     = 1'b1;
    localparam logic KIND_MOTOR  = 1'b0;
    localparam logic KIND_REPLY  = 1'b1;

    typedef enum logic [1:0] {
        DIR_STOP    = 2'd0,
        DIR_ADVANCE = 2'd1,
        DIR_RETREAT = 2'd2
    } dir_t;

    // Idle tick counter.
    localparam int IDLE_W = 7;
    localparam logic [IDLE_W-1:0] IDLE_LIMIT = 7'd10;
    localparam logic [IDLE_W-1:0] IDLE_WRAP  = 7'd10;

    // Status reply sequencing.
    localparam int REPLY_BYTES = 9;
    localparam int REPLY_IDX_W = $clog2(REPLY_BYTES);
    localparam logic [REPLY_IDX_W-1:0] REPLY_IDX_LAST = REPLY_IDX_W'(REPLY_BYTES - 1);

    // Magnitude to speed conversion, filled in at elaboration.
    localparam int SPEED_FULL = 1000;
    localparam int MAG_MAX    = 127;
    localparam int SPEED_W    = 10;

    typedef logic [SPEED_W-1:0] speed_lut_t [MAG_MAX+1];

    function automatic speed_lut_t build_speed_lut();
        speed_lut_t lut;
        for (int i = 0; i <= MAG_MAX; i++)
        begin
            lut[i] = SPEED_W'((i * SPEED_FULL) / MAG_MAX);
        end
        return lut;
    endfunction

    localparam speed_lut_t SPEED_LUT = build_speed_lut();

    // Byte idx of the status reply: 55 AA 06 cs 00 03 id 0D 0A.
    function automatic logic [7:0] reply_byte_at(
        input logic [REPLY_IDX_W-1:0] idx,
        input logic [7:0]             board
    );
        logic [7:0] b;
        case (idx)
            4'd0:    b = SYNC0;
            4'd1:    b = SYNC1;
            4'd2:    b = REPLY_LEN;
            4'd3:    b = REPLY_CTR + CMD_STATUS + board + TAIL_CR + TAIL_LF;
            4'd4:    b = REPLY_CTR;
            4'd5:    b = CMD_STATUS;
            4'd6:    b = board;
            4'd7:    b = TAIL_CR;
            4'd8:    b = TAIL_LF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### rtl/cfmd_in_if.sv
`timescale 1ns / 1ps

interface cfmd_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;
    logic       end_of_message;
    logic [7:0] board_id;

    modport source (output valid, op, rx_byte, end_of_message, board_id, input ready);
    modport sink   (input valid, op, rx_byte, end_of_message, board_id, output ready);
endinterface

### rtl/cfmd_out_if.sv
`timescale 1ns / 1ps

interface cfmd_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] left_dir;
    logic [9:0] left_rate;
    logic [1:0] right_dir;
    logic [9:0] right_rate;
    logic [7:0] reply_byte;
    logic       reply_last;

    modport source (output valid, kind, left_dir, left_rate, right_dir, right_rate,
                    reply_byte, reply_last, input ready);
    modport sink   (input valid, kind, left_dir, left_rate, right_dir, right_rate,
                    reply_byte, reply_last, output ready);
endinterface

### rtl/command_frame_motor_drive_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Command frame parser and motor drive. Message bytes and periodic ticks come in on
// the item channel; motor drive commands and status reply bytes leave on the result
// channel. An item is taken into an input register, decoded from there against the
// frame state, and its result (if any) lands in the result register; one item is
// accepted every cycle while the result side keeps up and no status reply is being
// sent. A status request produces nine reply beats through the single result
// register, and the item that follows it waits while those beats are sent. A
// stalled result side holds the input register once it is full.
module command_frame_motor_drive_core #(
    parameter int MAX_PAYLOAD = cfmd_pkg::MAX_PAYLOAD
) (
    input  logic        clk,
    input  logic        rst_n,
    cfmd_in_if.sink     item,
    cfmd_out_if.source  result
);
    import cfmd_pkg::*;

    localparam logic [7:0] LEN_TOP = 8'(MAX_PAYLOAD + 5);

    // Input register
    logic              stage_valid_reg;
    logic              stage_op_reg;
    logic [7:0]        stage_byte_reg;
    logic              stage_eom_reg;
    logic [7:0]        stage_board_reg;

    // Frame and mode state
    logic [POS_W-1:0]  pos_reg,     pos_next;
    logic [7:0]        len_reg,     len_next;
    logic [7:0]        cs_reg,      cs_next;
    logic [7:0]        sum_reg,     sum_next;
    logic              hdr_ok_reg,  hdr_ok_next;
    logic [7:0]        cmd_reg,     cmd_next;
    logic [7:0]        pay0_reg,    pay0_next;
    logic [7:0]        pay1_reg,    pay1_next;
    logic              control_reg, control_next;
    logic [IDLE_W-1:0] idle_reg,    idle_next;

    // Values after the current byte, before the end-of-message clear
    logic [POS_W-1:0]  upd_pos;
    logic [7:0]        upd_len, upd_cs, upd_sum, upd_cmd, upd_pay0, upd_pay1;
    logic              upd_hdr_ok;
    logic [IDLE_W-1:0] idle_inc;
    logic              frame_ok;

    // Result of the current item
    logic              res_valid;
    logic              res_kind;
    dir_t              res_ldir, res_rdir;
    logic [SPEED_W-1:0] res_lspeed, res_rspeed;
    logic [7:0]        res_byte;
    logic              res_start_reply;

    // Result register and reply sequencer
    logic              out_valid_reg;
    logic              out_kind_reg;
    dir_t              out_ldir_reg, out_rdir_reg;
    logic [SPEED_W-1:0] out_lspeed_reg, out_rspeed_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              reply_busy_reg;
    logic [REPLY_IDX_W-1:0] reply_idx_reg;
    logic [7:0]        reply_board_reg;

    logic              out_free;
    logic              proc_fire;

    assign out_free   = !out_valid_reg || result.ready;
    assign proc_fire  = stage_valid_reg && !reply_busy_reg && out_free;
    assign item.ready = !stage_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            stage_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            stage_op_reg    <= item.op;
            stage_byte_reg  <= item.rx_byte;
            stage_eom_reg   <= item.end_of_message;
            stage_board_reg <= item.board_id;
        end
    end

    always_comb
    begin
        pos_next        = pos_reg;
        len_next        = len_reg;
        cs_next         = cs_reg;
        sum_next        = sum_reg;
        hdr_ok_next     = hdr_ok_reg;
        cmd_next        = cmd_reg;
        pay0_next       = pay0_reg;
        pay1_next       = pay1_reg;
        control_next    = control_reg;
        idle_next       = idle_reg;

        upd_pos         = pos_reg;
        upd_len         = len_reg;
        upd_cs          = cs_reg;
        upd_sum         = sum_reg;
        upd_hdr_ok      = hdr_ok_reg;
        upd_cmd         = cmd_reg;
        upd_pay0        = pay0_reg;
        upd_pay1        = pay1_reg;
        idle_inc        = idle_reg + 1'b1;
        frame_ok        = 1'b0;

        res_valid       = 1'b0;
        res_kind        = KIND_MOTOR;
        res_ldir        = DIR_STOP;
        res_rdir        = DIR_STOP;
        res_lspeed      = '0;
        res_rspeed      = '0;
        res_byte        = 8'h00;
        res_start_reply = 1'b0;

        if (stage_op_reg == OP_TICK)
        begin
            // Motors are stopped once the drive has gone quiet for too long.
            if (control_reg && (idle_reg > IDLE_LIMIT))
            begin
                res_valid = 1'b1;
            end
            idle_next = (idle_inc == '0) ? IDLE_WRAP : idle_inc;
        end
        else
        begin
            if (pos_reg == POS_SYNC0)
            begin
                upd_hdr_ok = (stage_byte_reg == SYNC0);
            end
            else if (pos_reg == POS_SYNC1)
            begin
                if (stage_byte_reg != SYNC1)
                begin
                    upd_hdr_ok = 1'b0;
                end
            end
            else if (pos_reg == POS_LEN)
            begin
                upd_len = stage_byte_reg;
            end
            else if (pos_reg == POS_CS)
            begin
                upd_cs = stage_byte_reg;
            end
            else if ({1'b0, pos_reg} <= ({2'b00, len_reg} + 10'd2))
            begin
                upd_sum = sum_reg + stage_byte_reg;
                if (pos_reg == POS_CMD)
                begin
                    upd_cmd = stage_byte_reg;
                end
                else if ((pos_reg == POS_PAY0) && ({1'b0, pos_reg} <= {2'b00, len_reg}))
                begin
                    upd_pay0 = stage_byte_reg;
                end
                else if ((pos_reg == POS_PAY1) && ({1'b0, pos_reg} <= {2'b00, len_reg}))
                begin
                    upd_pay1 = stage_byte_reg;
                end
            end
            if (pos_reg < POS_LIMIT)
            begin
                upd_pos = pos_reg + 1'b1;
            end

            frame_ok = upd_hdr_ok
                && (upd_len >= LEN_MIN)
                && (upd_len <= LEN_TOP)
                && ({1'b0, upd_pos} >= ({2'b00, upd_len} + 10'd3))
                && (upd_sum == upd_cs);

            if (stage_eom_reg)
            begin
                // The frame state starts over after every message.
                pos_next    = '0;
                len_next    = '0;
                cs_next     = '0;
                sum_next    = '0;
                hdr_ok_next = 1'b0;
                cmd_next    = '0;
                pay0_next   = '0;
                pay1_next   = '0;
                if (frame_ok)
                begin
                    unique case (upd_cmd)
                        CMD_BOARD_MODE:
                        begin
                            control_next = 1'b0;
                        end
                        CMD_DRIVE_MODE:
                        begin
                            control_next = 1'b1;
                        end
                        CMD_MOTOR:
                        begin
                            if (control_reg)
                            begin
                                idle_next  = '0;
                                res_valid  = 1'b1;
                                res_ldir   = upd_pay0[7] ? DIR_RETREAT : DIR_ADVANCE;
                                res_rdir   = upd_pay1[7] ? DIR_RETREAT : DIR_ADVANCE;
                                res_lspeed = SPEED_LUT[upd_pay0[6:0]];
                                res_rspeed = SPEED_LUT[upd_pay1[6:0]];
                            end
                        end
                        CMD_STATUS:
                        begin
                            res_valid       = 1'b1;
                            res_kind        = KIND_REPLY;
                            res_byte        = reply_byte_at('0, stage_board_reg);
                            res_start_reply = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            else
            begin
                pos_next    = upd_pos;
                len_next    = upd_len;
                cs_next     = upd_cs;
                sum_next    = upd_sum;
                hdr_ok_next = upd_hdr_ok;
                cmd_next    = upd_cmd;
                pay0_next   = upd_pay0;
                pay1_next   = upd_pay1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            len_reg     <= '0;
            cs_reg      <= '0;
            sum_reg     <= '0;
            hdr_ok_reg  <= 1'b0;
            cmd_reg     <= '0;
            pay0_reg    <= '0;
            pay1_reg    <= '0;
            control_reg <= 1'b0;
            idle_reg    <= '0;
        end
        else if (proc_fire)
        begin
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            cs_reg      <= cs_next;
            sum_reg     <= sum_next;
            hdr_ok_reg  <= hdr_ok_next;
            cmd_reg     <= cmd_next;
            pay0_reg    <= pay0_next;
            pay1_reg    <= pay1_next;
            control_reg <= control_next;
            idle_reg    <= idle_next;
        end
    end

    // Result register control; the reply sequencer has priority over new items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            reply_busy_reg <= 1'b0;
            reply_idx_reg  <= '0;
        end
        else if (out_free)
        begin
            if (reply_busy_reg)
            begin
                out_valid_reg <= 1'b1;
                reply_idx_reg <= reply_idx_reg + 1'b1;
                if (reply_idx_reg == REPLY_IDX_LAST)
                begin
                    reply_busy_reg <= 1'b0;
                end
            end
            else
            begin
                out_valid_reg <= proc_fire && res_valid;
                if (proc_fire && res_start_reply)
                begin
                    reply_busy_reg <= 1'b1;
                    reply_idx_reg  <= REPLY_IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (reply_busy_reg)
            begin
                out_kind_reg   <= KIND_REPLY;
                out_ldir_reg   <= DIR_STOP;
                out_rdir_reg   <= DIR_STOP;
                out_lspeed_reg <= '0;
                out_rspeed_reg <= '0;
                out_byte_reg   <= reply_byte_at(reply_idx_reg, reply_board_reg);
                out_last_reg   <= (reply_idx_reg == REPLY_IDX_LAST);
            end
            else if (proc_fire)
            begin
                out_kind_reg    <= res_kind;
                out_ldir_reg    <= res_ldir;
                out_rdir_reg    <= res_rdir;
                out_lspeed_reg  <= res_lspeed;
                out_rspeed_reg  <= res_rspeed;
                out_byte_reg    <= res_byte;
                out_last_reg    <= 1'b0;
                reply_board_reg <= stage_board_reg;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = out_kind_reg;
    assign result.left_dir    = out_ldir_reg;
    assign result.left_rate   = out_lspeed_reg;
    assign result.right_dir   = out_rdir_reg;
    assign result.right_rate  = out_rspeed_reg;
    assign result.reply_byte  = out_byte_reg;
    assign result.reply_last  = out_last_reg;

    `ASSERT_IMPLIES(a_reply_holds_output, reply_busy_reg, out_valid_reg,
        "reply in progress without a valid result beat")
    `ASSERT_ALWAYS(a_no_decode_during_reply, !(reply_busy_reg && proc_fire),
        "item decoded while a status reply is still being sent")
    `ASSERT_IMPLIES(a_last_ends_reply, out_valid_reg && out_last_reg, !reply_busy_reg,
        "final reply beat shown while the sequencer is still busy")
    `ASSERT_IMPLIES(a_stop_has_no_speed,
        out_valid_reg && (out_kind_reg == KIND_MOTOR) && (out_ldir_reg == DIR_STOP),
        (out_lspeed_reg == '0) && (out_rspeed_reg == '0) && (out_rdir_reg == DIR_STOP),
        "stop command carries a speed")

endmodule

### dv/tb_command_frame_motor_drive_core.sv
`timescale 1ns / 1ps

module tb_command_frame_motor_drive_core;

    import cfmd_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 8;
    localparam int TOTAL_ITEMS      = 330;
    localparam int MAX_WAIT         = 14;
    localparam int LONG_HOLD_AT     = 60;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 20;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int REPORT_LIMIT     = 10;

    typedef enum {
        FLAW_NONE,
        FLAW_SYNC,
        FLAW_SUM,
        FLAW_SHORT,
        FLAW_EXTRA
    } frame_flaw_t;

    typedef struct {
        logic       op;
        logic [7:0] rx_byte;
        logic       eom;
        logic [7:0] board_id;
        bit         hold;
    } link_item_t;

    typedef struct {
        logic       kind;
        dir_t       left_dir;
        logic [9:0] left_rate;
        dir_t       right_dir;
        logic [9:0] right_rate;
        logic [7:0] reply_byte;
        logic       reply_last;
    } drive_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cfmd_in_if  item_if ();
    cfmd_out_if result_if ();

    command_frame_motor_drive_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = ~clk;
    end

    link_item_t    item_backlog [$];
    drive_result_t awaited_results [$];

    // Frame parser and motor state as the block should hold it.
    logic [POS_W-1:0]  rx_pos;
    logic [7:0]        frame_len;
    logic [7:0]        cs_field;
    logic [7:0]        sum_acc;
    logic              header_good;
    logic [7:0]        cmd_code;
    logic [7:0]        pay_first;
    logic [7:0]        pay_second;
    logic              ctrl_active;
    logic [IDLE_W-1:0] idle_count;

    int  fail_count = 0;
    int  queued_items = 0;
    bit  hold_next = 1'b0;

    function automatic void clear_frame_state();
        rx_pos      = '0;
        frame_len   = '0;
        cs_field    = '0;
        sum_acc     = '0;
        header_good = 1'b0;
        cmd_code    = '0;
        pay_first   = '0;
        pay_second  = '0;
    endfunction

    function automatic dir_t dir_from(logic [7:0] b);
        return b[7] ? DIR_RETREAT : DIR_ADVANCE;
    endfunction

    function automatic logic [9:0] speed_from(logic [7:0] b);
        return 10'((int'(b[6:0]) * SPEED_FULL) / MAG_MAX);
    endfunction

    function automatic drive_result_t blank_result();
        drive_result_t r;
        r.kind        = KIND_MOTOR;
        r.left_dir    = DIR_STOP;
        r.left_rate   = '0;
        r.right_dir   = DIR_STOP;
        r.right_rate  = '0;
        r.reply_byte  = '0;
        r.reply_last  = 1'b0;
        return r;
    endfunction

    // Works out what one accepted beat must produce and updates the state.
    function automatic void parse_and_drive(link_item_t it);
        drive_result_t r;
        logic [7:0]    reply [REPLY_BYTES];
        bit            frame_good;
        if (it.op == OP_TICK)
        begin
            if (ctrl_active && idle_count > IDLE_LIMIT)
                awaited_results.push_back(blank_result());
            idle_count = idle_count + 1'b1;
            if (idle_count == '0)
                idle_count = IDLE_WRAP;
            return;
        end
        if (rx_pos == POS_SYNC0)
            header_good = (it.rx_byte == SYNC0);
        else if (rx_pos == POS_SYNC1)
        begin
            if (it.rx_byte != SYNC1)
                header_good = 1'b0;
        end
        else if (rx_pos == POS_LEN)
            frame_len = it.rx_byte;
        else if (rx_pos == POS_CS)
            cs_field = it.rx_byte;
        else if (int'(rx_pos) <= int'(frame_len) + 2)
        begin
            sum_acc = sum_acc + it.rx_byte;
            if (rx_pos == POS_CMD)
                cmd_code = it.rx_byte;
            else if (rx_pos == POS_PAY0 && int'(rx_pos) <= int'(frame_len))
                pay_first = it.rx_byte;
            else if (rx_pos == POS_PAY1 && int'(rx_pos) <= int'(frame_len))
                pay_second = it.rx_byte;
        end
        if (rx_pos != POS_LIMIT)
            rx_pos = rx_pos + 1'b1;
        if (!it.eom)
            return;
        frame_good = header_good && frame_len >= LEN_MIN && frame_len <= LEN_MAX
                     && int'(rx_pos) >= int'(frame_len) + 3 && sum_acc == cs_field;
        if (frame_good)
        begin
            case (cmd_code)
                CMD_BOARD_MODE: ctrl_active = 1'b0;
                CMD_DRIVE_MODE: ctrl_active = 1'b1;
                CMD_MOTOR:
                begin
                    if (ctrl_active)
                    begin
                        idle_count    = '0;
                        r             = blank_result();
                        r.left_dir    = dir_from(pay_first);
                        r.left_rate   = speed_from(pay_first);
                        r.right_dir   = dir_from(pay_second);
                        r.right_rate  = speed_from(pay_second);
                        awaited_results.push_back(r);
                    end
                end
                CMD_STATUS:
                begin
                    reply[0] = SYNC0;
                    reply[1] = SYNC1;
                    reply[2] = REPLY_LEN;
                    reply[3] = REPLY_CTR + CMD_STATUS + it.board_id + TAIL_CR + TAIL_LF;
                    reply[4] = REPLY_CTR;
                    reply[5] = CMD_STATUS;
                    reply[6] = it.board_id;
                    reply[7] = TAIL_CR;
                    reply[8] = TAIL_LF;
                    for (int i = 0; i < REPLY_BYTES; i++)
                    begin
                        r            = blank_result();
                        r.kind       = KIND_REPLY;
                        r.reply_byte = reply[i];
                        r.reply_last = (i == REPLY_BYTES - 1);
                        awaited_results.push_back(r);
                    end
                end
                default: ;
            endcase
        end
        clear_frame_state();
    endfunction

    function automatic bit same_result(drive_result_t a, drive_result_t b);
        return a.kind === b.kind && a.left_dir === b.left_dir
               && a.left_rate === b.left_rate && a.right_dir === b.right_dir
               && a.right_rate === b.right_rate && a.reply_byte === b.reply_byte
               && a.reply_last === b.reply_last;
    endfunction

    function automatic string result_text(drive_result_t r);
        return $sformatf("kind=%0d left=%0d/%0d right=%0d/%0d reply=%02h last=%0d",
                         r.kind, r.left_dir, r.left_rate, r.right_dir, r.right_rate,
                         r.reply_byte, r.reply_last);
    endfunction

    // Stimulus builders.
    function automatic void push_item(logic op, logic [7:0] b, logic eom);
        link_item_t it;
        it.op       = op;
        it.rx_byte  = b;
        it.eom      = eom;
        it.board_id = 8'($urandom);
        it.hold     = hold_next;
        hold_next   = 1'b0;
        item_backlog.push_back(it);
        queued_items++;
    endfunction

    function automatic void push_tick();
        push_item(OP_TICK, 8'($urandom), 1'($urandom));
    endfunction

    function automatic logic [7:0] pick_magnitude();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'h7F;
            2:       return 8'h80;
            3:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_len();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(int'(LEN_MIN), int'(LEN_MAX)));
        return 8'($urandom_range(int'(LEN_MIN), int'(LEN_MIN) + 1));
    endfunction

    function automatic logic [7:0] pick_bad_len();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, int'(LEN_MIN) - 1));
        return 8'($urandom_range(int'(LEN_MAX) + 1, int'(LEN_MAX) + 8));
    endfunction

    function automatic void add_frame(logic [7:0] len, logic [7:0] cmd, logic [7:0] p0,
                                      logic [7:0] p1, frame_flaw_t flaw);
        logic [7:0] body [$];
        logic [7:0] cs_calc;
        body.push_back(SYNC0);
        body.push_back(SYNC1);
        body.push_back(len);
        body.push_back(8'h00);
        body.push_back(8'($urandom));
        body.push_back(cmd);
        for (int p = int'(POS_PAY0); p <= int'(len); p++)
            body.push_back(p == int'(POS_PAY0) ? p0 : p == int'(POS_PAY1) ? p1 : 8'($urandom));
        // The tails only count towards the sum, so odd values are legal too.
        body.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) : TAIL_CR);
        body.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) : TAIL_LF);
        cs_calc = '0;
        for (int i = int'(POS_CMD) - 1; i < body.size(); i++)
            cs_calc = cs_calc + body[i];
        body[POS_CS] = cs_calc;
        case (flaw)
            FLAW_SYNC:  body[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            FLAW_SUM:   body[POS_CS] ^= 8'($urandom_range(1, 255));
            FLAW_SHORT:
            begin
                repeat ($urandom_range(1, 3))
                    void'(body.pop_back());
            end
            FLAW_EXTRA:
            begin
                repeat ($urandom_range(1, 4))
                    body.push_back(8'($urandom));
            end
            default: ;
        endcase
        foreach (body[i])
        begin
            // A tick may fall in the middle of a message without disturbing it.
            if ($urandom_range(0, 15) == 0)
                push_tick();
            push_item(OP_BYTE, body[i], i == body.size() - 1);
        end
    endfunction

    function automatic void add_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            push_item(OP_BYTE, 8'($urandom), (i == n - 1) ? 1'b1 : ($urandom_range(0, 7) == 0));
    endfunction

    function automatic frame_flaw_t pick_flaw();
        case ($urandom_range(0, 3))
            0:       return FLAW_SYNC;
            1:       return FLAW_SUM;
            2:       return FLAW_SHORT;
            default: return FLAW_EXTRA;
        endcase
    endfunction

    // Sender side.
    link_item_t current_item;
    bit         offering = 1'b0;
    bit         calm_sender = 1'b0;
    int         send_gap = 0;
    int         accepted_items = 0;
    logic       next_valid;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_if.valid          <= 1'b0;
            item_if.op             <= OP_BYTE;
            item_if.rx_byte        <= '0;
            item_if.end_of_message <= 1'b0;
            item_if.board_id       <= '0;
            offering = 1'b0;
            send_gap = 0;
            clear_frame_state();
            ctrl_active = 1'b0;
            idle_count  = '0;
        end
        else
        begin
            next_valid = item_if.valid;
            if (item_if.valid && item_if.ready)
            begin
                parse_and_drive(current_item);
                accepted_items++;
                offering   = 1'b0;
                next_valid = 1'b0;
                send_gap   = calm_sender ? 0 : $urandom_range(0, MAX_WAIT);
                if (accepted_items % 40 == 0)
                    calm_sender = !calm_sender;
            end
            if (!offering && send_gap != 0)
                send_gap--;
            else if (!offering && item_backlog.size() != 0
                     && (!item_backlog[0].hold || awaited_results.size() == 0))
            begin
                current_item = item_backlog.pop_front();
                item_if.op             <= current_item.op;
                item_if.rx_byte        <= current_item.rx_byte;
                item_if.end_of_message <= current_item.eom;
                item_if.board_id       <= current_item.board_id;
                next_valid = 1'b1;
                offering   = 1'b1;
            end
            item_if.valid <= next_valid;
        end
    end

    // Receiver side.
    drive_result_t got;
    drive_result_t want;
    int            result_beats = 0;
    int            ready_stall = 0;
    bit            calm_receiver = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            ready_stall = 0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                got.kind        = result_if.kind;
                got.left_dir    = dir_t'(result_if.left_dir);
                got.left_rate   = result_if.left_rate;
                got.right_dir   = dir_t'(result_if.right_dir);
                got.right_rate  = result_if.right_rate;
                got.reply_byte  = result_if.reply_byte;
                got.reply_last  = result_if.reply_last;
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected beat: %s", result_text(got));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (!same_result(want, got))
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("mismatch on beat %0d: expected %s, got %s",
                                     result_beats, result_text(want), result_text(got));
                    end
                end
                result_beats++;
                // One long hold-off lets the block back up and stall its input.
                if (result_beats == LONG_HOLD_AT)
                    ready_stall = LONG_HOLD_CYCLES;
                else
                    ready_stall = calm_receiver ? 0 : $urandom_range(0, MAX_WAIT);
                if (result_beats % 50 == 0)
                    calm_receiver = !calm_receiver;
            end
            else if (ready_stall != 0)
                ready_stall--;
            result_if.ready <= (ready_stall == 0);
        end
    end

    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int  directed_count;
        int  pick;
        bit  pause_done;
        item_if.valid          = 1'b0;
        item_if.op             = OP_BYTE;
        item_if.rx_byte        = '0;
        item_if.end_of_message = 1'b0;
        item_if.board_id       = '0;
        result_if.ready        = 1'b0;
        pause_done    = 1'b0;

        // Directed: modes, motor extremes, idle stop, status and every way to lose a frame.
        add_frame(LEN_MIN, CMD_STATUS, 8'h00, 8'h00, FLAW_NONE);
        add_frame(LEN_MIN, CMD_MOTOR, 8'hFF, 8'h7F, FLAW_NONE);
        add_frame(LEN_MIN, CMD_DRIVE_MODE, 8'h00, 8'h00, FLAW_NONE);
        add_frame(LEN_MIN, CMD_MOTOR, 8'hFF, 8'h00, FLAW_NONE);
        add_frame(LEN_MIN + 1, CMD_MOTOR, 8'h00, 8'h80, FLAW_NONE);
        add_frame(LEN_MAX, CMD_MOTOR, 8'h7F, 8'h81, FLAW_NONE);
        // A long run of ticks in control mode stops the motors and walks the idle count
        // through its wrap.
        repeat (135)
            push_tick();
        add_frame(LEN_MIN, CMD_STATUS + 8'd1, 8'h00, 8'h00, FLAW_NONE);
        add_frame(LEN_MIN + 2, 8'hFF, 8'h55, 8'hAA, FLAW_NONE);
        add_frame(LEN_MIN, CMD_STATUS, 8'h00, 8'h00, FLAW_SYNC);
        add_frame(LEN_MIN - 1, CMD_STATUS, 8'h00, 8'h00, FLAW_NONE);
        add_frame(LEN_MAX + 1, CMD_STATUS, 8'h00, 8'h00, FLAW_NONE);
        add_frame(LEN_MIN + 1, CMD_MOTOR, 8'h12, 8'h34, FLAW_SHORT);
        add_frame(LEN_MIN + 1, CMD_MOTOR, 8'h12, 8'h34, FLAW_SUM);
        add_frame(LEN_MIN, CMD_STATUS, 8'h00, 8'h00, FLAW_EXTRA);
        add_frame(LEN_MIN, CMD_BOARD_MODE, 8'h00, 8'h00, FLAW_NONE);
        add_frame(LEN_MIN + 1, CMD_MOTOR, 8'h40, 8'hC0, FLAW_NONE);
        directed_count = queued_items;

        // Random part starts from an empty pipeline.
        hold_next = 1'b1;
        while (queued_items < TOTAL_ITEMS)
        begin
            if (!pause_done && queued_items > directed_count + 10)
            begin
                hold_next  = 1'b1;
                pause_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                repeat ($urandom_range(1, 6))
                    push_tick();
            end
            else if (pick < 18)
                add_noise();
            else if (pick < 28)
                add_frame(pick_len(), 8'($urandom_range(0, 3)), pick_magnitude(),
                          pick_magnitude(), pick_flaw());
            else if (pick < 31)
                add_frame(pick_bad_len(), 8'($urandom_range(0, 3)), 8'h00, 8'h00, FLAW_NONE);
            else if (pick < 40)
                add_frame(pick_len(), CMD_DRIVE_MODE, pick_magnitude(), pick_magnitude(),
                          FLAW_NONE);
            else if (pick < 44)
                add_frame(pick_len(), CMD_BOARD_MODE, pick_magnitude(), pick_magnitude(),
                          FLAW_NONE);
            else if (pick < 71)
                add_frame(pick_len(), CMD_MOTOR, pick_magnitude(), pick_magnitude(),
                          FLAW_NONE);
            else if (pick < 89)
                add_frame(pick_len(), CMD_STATUS, pick_magnitude(), pick_magnitude(),
                          FLAW_NONE);
            else if (pick < 96)
                add_frame(pick_len(), ($urandom_range(0, 1) == 0) ? CMD_STATUS + 8'd1
                          : 8'($urandom_range(4, 255)), pick_magnitude(), pick_magnitude(),
                          FLAW_NONE);
            else
                add_frame(pick_len(), 8'($urandom_range(0, 3)), pick_magnitude(),
                          pick_magnitude(), FLAW_EXTRA);
        end

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        while (item_backlog.size() != 0 || offering)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### command_frame_motor_drive_core.f
+incdir+rtl
rtl/cfmd_pkg.sv
rtl/cfmd_in_if.sv
rtl/cfmd_out_if.sv
rtl/command_frame_motor_drive_core.sv
dv/tb_command_frame_motor_drive_core.sv
